// ----- design/response_frame_checker_core_macros.svh -----
// Assertion macros shared by the response frame checker RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH
`define RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH

// The property must hold at every sampled clock edge outside reset.
`define RFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("response frame checker: assertion failed");

// The condition must never be seen at a sampled clock edge outside reset.
`define RFC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("response frame checker: forbidden condition seen");

`endif

// ----- design/rfc_pkg.sv -----
// Package for the response frame checker: word types, result codes and CRC constants.
// It has no dependencies. The CRC unit, the frame tracker and the core import it.
`timescale 1ns / 1ps

package rfc_pkg;

    // One received byte of a response frame.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_word_t;

    // The verdict on one complete frame.
    typedef struct packed {
        logic [1:0] result_code;
        logic [7:0] device_status;
        logic       status_present;
    } out_word_t;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_CRC_ERR  = 2'd1;
    localparam logic [1:0] RES_SIZE_ERR = 2'd2;

    localparam logic [15:0] CRC_POLY         = 16'h8005;
    localparam logic [7:0]  STATUS_FRAME_LEN = 8'd4;
    localparam logic [7:0]  MAX_FRAME        = 8'd128;
    localparam logic [7:0]  COUNT_MAX        = 8'hFF;

endpackage

// ----- design/rfc_crc_byte.sv -----
// Byte-wide CRC-16 update, polynomial 0x8005, data taken least significant bit first.
// Depends on rfc_pkg for the polynomial.
`timescale 1ns / 1ps

module rfc_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import rfc_pkg::*;

    always_comb
    begin
        logic [15:0] crc;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (data[i] != crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        crc_out = crc;
    end

endmodule

// ----- design/rfc_frame_tracker.sv -----
// Per-frame state of the response frame checker: byte count, length, CRCs, status byte.
// Computes the verdict for a closing byte. Depends on rfc_pkg and rfc_crc_byte.
`timescale 1ns / 1ps

module rfc_frame_tracker #(
    parameter logic [7:0] MAX_LEN = rfc_pkg::MAX_FRAME
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rfc_pkg::in_word_t word,
    output rfc_pkg::out_word_t verdict
);
    import rfc_pkg::*;

    logic [7:0]  byte_count_reg,   byte_count_next;
    logic [7:0]  frame_length_reg;
    logic [15:0] crc_accum_reg,    crc_accum_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [7:0]  status_byte_reg,  status_byte_next;

    logic [7:0]  len;
    logic [8:0]  pos_plus2;
    logic        in_frame;
    logic [15:0] crc_updated;

    rfc_crc_byte u_crc (
        .crc_in  (crc_accum_reg),
        .data    (word.rx_byte),
        .crc_out (crc_updated)
    );

    // The length byte is used directly on the first byte of a frame.
    assign len       = (byte_count_reg == 8'd0) ? word.rx_byte : frame_length_reg;
    assign pos_plus2 = {1'b0, byte_count_reg} + 9'd2;
    assign in_frame  = byte_count_reg < len;

    always_comb
    begin
        crc_accum_next    = crc_accum_reg;
        received_crc_next = received_crc_reg;
        status_byte_next  = status_byte_reg;
        if (in_frame)
        begin
            if (pos_plus2 < {1'b0, len})
            begin
                crc_accum_next = crc_updated;
            end
            else if (pos_plus2 == {1'b0, len})
            begin
                received_crc_next[7:0] = word.rx_byte;
            end
            else
            begin
                received_crc_next[15:8] = word.rx_byte;
            end
            if (byte_count_reg == 8'd1)
            begin
                status_byte_next = word.rx_byte;
            end
        end
        byte_count_next = (byte_count_reg == COUNT_MAX) ? COUNT_MAX : byte_count_reg + 8'd1;
    end

    always_comb
    begin
        verdict = '0;
        priority if (len < STATUS_FRAME_LEN || len > MAX_LEN || byte_count_next < len)
        begin
            verdict.result_code = RES_SIZE_ERR;
        end
        else if (crc_accum_next != received_crc_next)
        begin
            verdict.result_code = RES_CRC_ERR;
        end
        else
        begin
            verdict.result_code = RES_OK;
            if (len == STATUS_FRAME_LEN)
            begin
                verdict.device_status  = status_byte_next;
                verdict.status_present = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            crc_accum_reg    <= '0;
            received_crc_reg <= '0;
            status_byte_reg  <= '0;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                byte_count_reg   <= '0;
                frame_length_reg <= '0;
                crc_accum_reg    <= '0;
                received_crc_reg <= '0;
                status_byte_reg  <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                frame_length_reg <= len;
                crc_accum_reg    <= crc_accum_next;
                received_crc_reg <= received_crc_next;
                status_byte_reg  <= status_byte_next;
            end
        end
    end

endmodule

// ----- design/response_frame_checker_core.sv -----
// Response frame checker core: input word register, frame tracker and result register.
// Depends on rfc_pkg, rfc_frame_tracker and the assertion macro header.
//
// Usage. The input channel (in_valid, in_ready, in_data) carries one received
// byte per word, together with a flag that marks the final byte of a response.
// The first byte of each frame is its length. Only the word that carries the
// last flag produces an output word on (out_valid, out_ready, out_data). That
// word holds a result code (success, CRC mismatch or size error) and, for a
// successful four-byte frame, the device status byte.
// Latency: a closing word is registered in the input register when it is accepted,
// checked by the frame tracker and captured in the output register when the
// tracker consumes it, which waits while an unread verdict fills that register.
// Throughput: one word per cycle unless a closing word waits behind a full
// output register. The tracker's byte-wide CRC unit updates a byte per cycle.
// Reset: an active-low asynchronous rst_n empties both registers and clears the
// frame state, so the next accepted word is taken as a length byte.
// Stalls: while an unread verdict waits in the output register, data bytes keep
// flowing. A second closing word waits in the input register, and in_ready
// falls only once that register is full and cannot drain.
`timescale 1ns / 1ps
`include "response_frame_checker_core_macros.svh"

module response_frame_checker_core #(
    parameter logic [7:0] MAX_LEN = rfc_pkg::MAX_FRAME
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rfc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rfc_pkg::out_word_t out_data
);
    import rfc_pkg::*;

    // Input stage: holds one accepted word until the tracker consumes it.
    logic      in_vld_reg;
    in_word_t  in_word_reg;

    // Output stage: holds one verdict until the receiver takes it.
    logic      out_vld_reg;
    out_word_t out_word_reg;

    out_word_t verdict;
    logic      step;
    logic      in_fire;

    // A data byte can always be consumed. A closing byte needs room in the
    // output register, which is there when it is empty or is read this cycle.
    assign step     = in_vld_reg && (!in_word_reg.last_byte || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;
    assign in_fire  = in_valid && in_ready;

    rfc_frame_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .word    (in_word_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (step)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step && in_word_reg.last_byte)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_word_reg.last_byte)
        begin
            out_word_reg <= verdict;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

    // A verdict only appears after a closing byte was consumed.
    `RFC_ASSERT(a_verdict_from_last, $rose(out_vld_reg) |-> $past(step && in_word_reg.last_byte))
    // The result code is never the unused encoding.
    `RFC_ASSERT_NEVER(a_code_legal, out_vld_reg && out_word_reg.result_code > RES_SIZE_ERR)
    // A status byte is reported only with a successful check.
    `RFC_ASSERT(a_status_ok, (out_vld_reg && out_word_reg.status_present)
        |-> (out_word_reg.result_code == RES_OK))
    // The input side stalls only when a closing byte waits behind a full output.
    `RFC_ASSERT(a_stall_cause, !in_ready
        |-> (in_vld_reg && in_word_reg.last_byte && out_vld_reg && !out_ready))

endmodule
